// ----- hdl/gyro_bias_calibrate_subtract_assert.svh -----
// Assertion macros for the gyro bias calibration block.
// Included by the RTL file that checks its own control logic.
`ifndef GYRO_BIAS_CALIBRATE_SUBTRACT_ASSERT_SVH
`define GYRO_BIAS_CALIBRATE_SUBTRACT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gbcs_pkg.sv -----
// Shared constants for the gyro bias calibration block.
// No dependencies.
`default_nettype none

package gbcs_pkg;

  localparam int CALIB_W         = 16;
  localparam logic [CALIB_W-1:0] CALIB_RESET = 16'd200;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int NUM_AXES        = 3;
  localparam int AXIS_W          = 2;

endpackage

`default_nettype wire

// ----- hdl/gyro_bias_calibrate_subtract.sv -----
// Gyro bias calibration by averaging, followed by bias subtraction.
// Depends on gbcs_pkg and gyro_bias_calibrate_subtract_assert.svh.
//
//  Channel  Signals                                 Direction  Beat
//  in       in_valid/in_ready, in_gyro_x/y/z        input      one raw sample
//  out      out_valid/out_ready, out_rate_x/y/z     output     one corrected sample
//  cfg      cfg_wr_en, cfg_wr_data                  input      calib_count write
//
// A calibration sample is added to the sums and gives no beat.
// After the last calibration sample, one restoring divider computes the three biases
// in turn, with in_ready low. After that, one sample per cycle while out_ready is high
// or no beat is pending; the output register drains while the next is accepted.
// Reset is synchronous, active low, and restarts calibration with calib_count at 200.
`default_nettype none
`include "gyro_bias_calibrate_subtract_assert.svh"

module gyro_bias_calibrate_subtract #(
  parameter int SAMPLE_BITS = gbcs_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = gbcs_pkg::COUNT_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  signed [SAMPLE_BITS-1:0]      in_gyro_x,
  input  wire  signed [SAMPLE_BITS-1:0]      in_gyro_y,
  input  wire  signed [SAMPLE_BITS-1:0]      in_gyro_z,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_rate_x,
  output logic signed [SAMPLE_BITS-1:0]      out_rate_y,
  output logic signed [SAMPLE_BITS-1:0]      out_rate_z,
  input  wire                                cfg_wr_en,
  input  wire         [gbcs_pkg::CALIB_W-1:0] cfg_wr_data
);
  import gbcs_pkg::*;

  localparam int SUM_W   = SAMPLE_BITS + COUNT_BITS;
  localparam int STEP_W  = $clog2(SUM_W);
  localparam int CEXT_W  = (COUNT_BITS > CALIB_W) ? COUNT_BITS : CALIB_W;

  localparam logic [STEP_W-1:0]     STEP_LAST = STEP_W'(SUM_W - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [CEXT_W-1:0]     CNT_MAX_EXT = CEXT_W'(CNT_MAX);
  localparam logic [SUM_W-1:0]      POS_LIM =
    {{(COUNT_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SUM_W-1:0]      NEG_LIM = POS_LIM + SUM_W'(1);
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
  localparam logic [AXIS_W-1:0]     AXIS_LAST = AXIS_W'(NUM_AXES - 1);

  localparam logic [2:0] ST_ACC   = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_STORE = 3'd3;
  localparam logic [2:0] ST_RUN   = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [CALIB_W-1:0]            calib_r, calib_nxt;
  logic [COUNT_BITS-1:0]         seen_r, seen_nxt;
  logic [COUNT_BITS-1:0]         div_n_r, div_n_nxt;
  logic signed [SUM_W-1:0]       sum_r [NUM_AXES];
  logic signed [SUM_W-1:0]       sum_nxt [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] bias_r [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] bias_nxt [NUM_AXES];
  logic [AXIS_W-1:0]             axis_r, axis_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  logic [COUNT_BITS-1:0]         rem_r, rem_nxt;
  logic [SUM_W-1:0]              quo_r, quo_nxt;
  logic                          neg_r, neg_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] rate_r [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] rate_nxt [NUM_AXES];

  logic signed [SAMPLE_BITS-1:0] smp [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] corr [NUM_AXES];
  logic signed [SAMPLE_BITS:0]   diff [NUM_AXES];
  logic [CEXT_W-1:0]             calib_ext;
  logic [COUNT_BITS-1:0]         eff_n;
  logic                          in_acc;
  logic [COUNT_BITS:0]           rem_sh;
  logic [COUNT_BITS:0]           rem_sub;
  logic                          rem_ge;
  logic signed [SUM_W-1:0]       sel_sum;
  logic [SUM_W-1:0]              quo_neg;
  logic signed [SAMPLE_BITS-1:0] bias_val;

  assign smp[0] = in_gyro_x;
  assign smp[1] = in_gyro_y;
  assign smp[2] = in_gyro_z;

  assign in_ready   = (state_r == ST_ACC) ||
                      ((state_r == ST_RUN) && (!out_valid_r || out_ready));
  assign in_acc     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_rate_x = rate_r[0];
  assign out_rate_y = rate_r[1];
  assign out_rate_z = rate_r[2];

  always_comb begin
    calib_ext = CEXT_W'(calib_r);
    if (calib_ext == '0) begin
      eff_n = COUNT_BITS'(1);
    end else if (calib_ext > CNT_MAX_EXT) begin
      eff_n = CNT_MAX;
    end else begin
      eff_n = COUNT_BITS'(calib_ext);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      diff[i] = {smp[i][SAMPLE_BITS-1], smp[i]} - {bias_r[i][SAMPLE_BITS-1], bias_r[i]};
      if (diff[i][SAMPLE_BITS] != diff[i][SAMPLE_BITS-1]) begin
        corr[i] = diff[i][SAMPLE_BITS] ? SMP_MIN : SMP_MAX;
      end else begin
        corr[i] = diff[i][SAMPLE_BITS-1:0];
      end
    end
  end

  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, div_n_r};
  assign rem_sub = rem_sh - {1'b0, div_n_r};
  assign sel_sum = sum_r[axis_r];
  assign quo_neg = ~quo_r + SUM_W'(1);

  always_comb begin
    if (neg_r) begin
      bias_val = (quo_r > NEG_LIM) ? SMP_MIN : quo_neg[SAMPLE_BITS-1:0];
    end else begin
      bias_val = (quo_r > POS_LIM) ? SMP_MAX : quo_r[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    calib_nxt     = cfg_wr_en ? cfg_wr_data : calib_r;
    seen_nxt      = seen_r;
    div_n_nxt     = div_n_r;
    axis_nxt      = axis_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    for (int i = 0; i < NUM_AXES; i++) begin
      sum_nxt[i]  = sum_r[i];
      bias_nxt[i] = bias_r[i];
      rate_nxt[i] = rate_r[i];
    end

    unique case (state_r)
      ST_ACC: begin
        if (in_acc) begin
          for (int i = 0; i < NUM_AXES; i++) begin
            sum_nxt[i] = sum_r[i] + SUM_W'(smp[i]);
          end
          seen_nxt = (seen_r != CNT_MAX) ? seen_r + COUNT_BITS'(1) : seen_r;
          if (seen_nxt >= eff_n) begin
            div_n_nxt = eff_n;
            axis_nxt  = '0;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        neg_nxt   = sel_sum[SUM_W-1];
        quo_nxt   = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt  = rem_ge ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
        quo_nxt  = {quo_r[SUM_W-2:0], rem_ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        bias_nxt[axis_r] = bias_val;
        if (axis_r == AXIS_LAST) begin
          state_nxt = ST_RUN;
        end else begin
          axis_nxt  = axis_r + AXIS_W'(1);
          state_nxt = ST_LOAD;
        end
      end
      ST_RUN: begin
        if (in_acc) begin
          out_valid_nxt = 1'b1;
          for (int i = 0; i < NUM_AXES; i++) begin
            rate_nxt[i] = corr[i];
          end
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      calib_r     <= CALIB_RESET;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        sum_r[i]  <= '0;
        bias_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      calib_r     <= calib_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_AXES; i++) begin
        sum_r[i]  <= sum_nxt[i];
        bias_r[i] <= bias_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    div_n_r <= div_n_nxt;
    axis_r  <= axis_nxt;
    step_r  <= step_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    neg_r   <= neg_nxt;
    for (int i = 0; i < NUM_AXES; i++) begin
      rate_r[i] <= rate_nxt[i];
    end
  end

  `GBCS_ASSERT_SAME(a_out_only_run, out_valid_r, state_r == ST_RUN,
    "Output beat pending outside normal operation.")
  `GBCS_ASSERT_SAME(a_rem_below_div, state_r == ST_DIV, rem_r < div_n_r,
    "Divider remainder is not below the divisor.")
  `GBCS_ASSERT_NEXT(a_cal_end_load,
    (state_r == ST_ACC) && in_acc && (seen_nxt >= eff_n), state_r == ST_LOAD,
    "Calibration end did not start the bias division.")
  `GBCS_ASSERT_NEXT(a_last_axis_run,
    (state_r == ST_STORE) && (axis_r == AXIS_LAST), state_r == ST_RUN,
    "Last bias stored but normal operation did not begin.")

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for gyro_bias_calibrate_subtract: calibration, bias saturation and rate checks.
// Depends on gbcs_pkg and the RTL top level; a scoreboard class predicts every output beat.

import gbcs_pkg::*;

typedef logic [SAMPLE_BITS_DEF-1:0] sample_t;
typedef logic [NUM_AXES-1:0][SAMPLE_BITS_DEF-1:0] triple_t;

class gyro_rate_tracker;
  logic [COUNT_BITS_DEF-1:0] calib_count;
  logic [COUNT_BITS_DEF-1:0] samples_seen;
  logic signed [SAMPLE_BITS_DEF+COUNT_BITS_DEF-1:0] axis_sum [NUM_AXES];
  sample_t axis_bias [NUM_AXES];
  bit bias_ready;
  triple_t pending_rates [$];
  int mismatches;

  function new();
    calib_count = CALIB_RESET;
    samples_seen = '0;
    bias_ready = 1'b0;
    mismatches = 0;
    for (int i = 0; i < NUM_AXES; i++) begin
      axis_sum[i] = '0;
      axis_bias[i] = '0;
    end
  endfunction

  function void set_calib_count(logic [CALIB_W-1:0] value);
    calib_count = value;
  endfunction

  function int pending_count();
    return pending_rates.size();
  endfunction

  function sample_t clamp_sample(longint value);
    longint hi;
    hi = (longint'(1) << (SAMPLE_BITS_DEF - 1)) - 1;
    if (value > hi) return sample_t'(hi);
    if (value < -hi - 1) return sample_t'(-hi - 1);
    return sample_t'(value);
  endfunction

  function longint effective_count();
    longint c;
    longint cmax;
    c = calib_count;
    cmax = (longint'(1) << COUNT_BITS_DEF) - 1;
    if (c == 0) c = 1;
    if (c > cmax) c = cmax;
    return c;
  endfunction

  function void take_sample(triple_t s);
    longint n;
    triple_t rate;
    if (!bias_ready) begin
      n = effective_count();
      for (int i = 0; i < NUM_AXES; i++) axis_sum[i] = axis_sum[i] + signed'(s[i]);
      if (samples_seen != '1) samples_seen = samples_seen + 1'b1;
      if (longint'(samples_seen) >= n) begin
        for (int i = 0; i < NUM_AXES; i++) axis_bias[i] = clamp_sample(longint'(axis_sum[i]) / n);
        bias_ready = 1'b1;
      end
    end else begin
      for (int i = 0; i < NUM_AXES; i++) begin
        rate[i] = clamp_sample(longint'(signed'(s[i])) - longint'(signed'(axis_bias[i])));
      end
      pending_rates.push_back(rate);
    end
  endfunction

  function void compare_rate(triple_t got);
    triple_t want;
    string tag;
    if (pending_rates.size() == 0) begin
      $error("Output beat with no sample pending: rate_x=%0d rate_y=%0d rate_z=%0d",
             signed'(got[0]), signed'(got[1]), signed'(got[2]));
      mismatches++;
      return;
    end
    want = pending_rates.pop_front();
    for (int i = 0; i < NUM_AXES; i++) begin
      if (got[i] !== want[i]) begin
        tag = (i == 0) ? "rate_x" : (i == 1) ? "rate_y" : "rate_z";
        $error("%s: expected %0d, actual %0d", tag, signed'(want[i]), signed'(got[i]));
        mismatches++;
      end
    end
  endfunction
endclass

module tb_top;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  localparam int CAL_LEAD       = 40;
  localparam int PHASE_SAMPLES  = 190;
  localparam int NUM_PHASES     = 8;
  localparam int SETTLE_CYCLES  = 120;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t in_gyro_x = '0;
  sample_t in_gyro_y = '0;
  sample_t in_gyro_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sample_t out_rate_x;
  sample_t out_rate_y;
  sample_t out_rate_z;
  logic cfg_wr_en = 1'b0;
  logic [CALIB_W-1:0] cfg_wr_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  gyro_rate_tracker tracker = new();

  gyro_bias_calibrate_subtract dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_gyro_x   (in_gyro_x),
    .in_gyro_y   (in_gyro_y),
    .in_gyro_z   (in_gyro_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rate_x  (out_rate_x),
    .out_rate_y  (out_rate_y),
    .out_rate_z  (out_rate_z),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      tracker.take_sample({in_gyro_z, in_gyro_y, in_gyro_x});
    end
    if (rst_n && out_valid && out_ready) begin
      tracker.compare_rate({out_rate_z, out_rate_y, out_rate_x});
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic sample_t edge_value(int k);
    case (k % 5)
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return '1;
      default: return 16'sh0001;
    endcase
  endfunction

  function automatic sample_t rand_sample();
    if ($urandom_range(7) == 0) return edge_value($urandom_range(4));
    return sample_t'($urandom);
  endfunction

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 74;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 74;
      end
      default: begin
        send_idle_pct = 18;
        recv_stall_pct = 18;
      end
    endcase
  endtask

  task automatic send_sample(triple_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_gyro_x <= s[0];
    in_gyro_y <= s[1];
    in_gyro_z <= s[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_calib_count(logic [CALIB_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    tracker.set_calib_count(value);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    triple_t s;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Start with the largest count, then lower it below the samples already taken, so
    // the next beat ends calibration and the x and y biases saturate.
    write_calib_count(16'hFFFF);
    set_idling(IDLE_BOTH);
    for (int k = 0; k < CAL_LEAD; k++) begin
      if (k < 4) begin
        s[0] = 16'sh7FFF;
        s[1] = 16'sh8000;
        s[2] = edge_value(k);
      end else begin
        s[0] = sample_t'($urandom_range(32767, 16384));
        s[1] = sample_t'(-int'($urandom_range(32768, 16384)));
        s[2] = sample_t'($urandom);
      end
      send_sample(s);
    end
    settle();
    write_calib_count(CALIB_W'($urandom_range(20, 2)));
    send_sample({rand_sample(), sample_t'($urandom_range(32767, 16384)), 16'sh7FFF});

    set_idling(IDLE_NONE);
    for (int k = 0; k < 15; k++) begin
      send_sample({edge_value(2 * (k / 5) + k), edge_value(k / 5 + k), edge_value(k)});
    end

    // Count writes after calibration must leave the biases alone.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p == 0) write_calib_count('0);
      else if (p == 1) write_calib_count(16'hFFFF);
      else write_calib_count(CALIB_W'($urandom_range(65535)));
      set_idling(idle_mode_e'(p % 4));
      repeat (PHASE_SAMPLES) send_sample({rand_sample(), rand_sample(), rand_sample()});
    end
    settle();

    if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
